// ===== hdl/dsbf_pkg.sv =====
// shared types and constants for the back-to-front depth sorter
package dsbf_pkg;

   localparam int MAX_OBJECTS_DEF = 64;
   localparam int TAG_W           = 16;
   localparam int COORD_W         = 24;
   localparam int PROD_W          = 2 * COORD_W;
   localparam int KEY_W           = 50;
   localparam int CSR_ADDR_W      = 4;
   localparam int CSR_DATA_W      = 32;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_W     = 2;
   localparam int QUEUE_CNT_W     = QUEUE_PTR_W + 1;
   localparam int REQ_DATA_W      = TAG_W + 3 * COORD_W;
   localparam int RSP_DATA_W      = ((TAG_W + KEY_W + 7) / 8) * 8;

   // register index, taken from paddr word address
   typedef enum logic [1:0] {
      CSR_CAMERA_X = 2'd0,
      CSR_CAMERA_Y = 2'd1,
      CSR_CAMERA_Z = 2'd2
   } csr_reg_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } camera_type;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [KEY_W-1:0] key;
      logic             last;
   } sort_item_type;

   typedef struct packed {
      logic          push;
      sort_item_type item;
   } queue_write_type;

   typedef struct packed {
      logic          valid;
      sort_item_type item;
   } queue_head_type;

   typedef enum logic {
      BACK_LOAD = 1'b0,
      BACK_EMIT = 1'b1
   } back_state_type;

endpackage

// ===== hdl/dsbf_csr.sv =====
// camera position registers behind the apb-style configuration port
module dsbf_csr
   import dsbf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output camera_type            camera
);

   camera_type  camera_ff, camera_in;
   csr_reg_type sel;
   logic        wr_en;

   assign sel        = csr_reg_type'(csr_paddr[3:2]);
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      camera_in  = camera_ff;
      csr_prdata = '0;
      unique case (sel)
         CSR_CAMERA_X: begin
            csr_prdata = {{(CSR_DATA_W-COORD_W){1'b0}}, camera_ff.x};
            if (wr_en) camera_in.x = csr_pwdata[COORD_W-1:0];
         end
         CSR_CAMERA_Y: begin
            csr_prdata = {{(CSR_DATA_W-COORD_W){1'b0}}, camera_ff.y};
            if (wr_en) camera_in.y = csr_pwdata[COORD_W-1:0];
         end
         CSR_CAMERA_Z: begin
            csr_prdata = {{(CSR_DATA_W-COORD_W){1'b0}}, camera_ff.z};
            if (wr_en) camera_in.z = csr_pwdata[COORD_W-1:0];
         end
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         camera_ff <= '0;
      end else begin
         camera_ff <= camera_in;
      end
   end

   assign camera = camera_ff;

endmodule

// ===== hdl/dsbf_front.sv =====
// front end: accepts objects and computes squared distance in two stages
module dsbf_front
   import dsbf_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [TAG_W-1:0]          in_tag,
   input  logic signed [COORD_W-1:0] in_x,
   input  logic signed [COORD_W-1:0] in_y,
   input  logic signed [COORD_W-1:0] in_z,
   input  logic                      in_last,
   input  camera_type                camera,
   input  logic [QUEUE_CNT_W-1:0]    queue_count,
   output queue_write_type           queue_wr
);

   logic                   accept;
   logic signed [COORD_W:0] dx, dy, dz;

   // stage 1: absolute differences
   logic                   v1_ff, v1_in;
   logic [TAG_W-1:0]       tag1_ff;
   logic                   last1_ff;
   logic [COORD_W-1:0]     ax1_ff, ay1_ff, az1_ff;

   // stage 2: squares
   logic                   v2_ff, v2_in;
   logic [TAG_W-1:0]       tag2_ff;
   logic                   last2_ff;
   logic [PROD_W-1:0]      px2_ff, py2_ff, pz2_ff;

   logic [QUEUE_CNT_W:0]   occupancy;

   function automatic logic [COORD_W-1:0] abs_diff(input logic signed [COORD_W:0] d);
      logic signed [COORD_W:0] m;
      m = d[COORD_W] ? -d : d;
      return m[COORD_W-1:0];
   endfunction

   // items in flight must always find room in the queue
   assign occupancy = {1'b0, queue_count} + (QUEUE_CNT_W+1)'(v1_ff) + (QUEUE_CNT_W+1)'(v2_ff);
   assign in_ready  = occupancy < (QUEUE_CNT_W+1)'(QUEUE_DEPTH);
   assign accept    = in_valid & in_ready;

   assign dx = {in_x[COORD_W-1], in_x} - {camera.x[COORD_W-1], camera.x};
   assign dy = {in_y[COORD_W-1], in_y} - {camera.y[COORD_W-1], camera.y};
   assign dz = {in_z[COORD_W-1], in_z} - {camera.z[COORD_W-1], camera.z};

   assign v1_in = accept;
   assign v2_in = v1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      tag1_ff  <= in_tag;
      last1_ff <= in_last;
      ax1_ff   <= abs_diff(dx);
      ay1_ff   <= abs_diff(dy);
      az1_ff   <= abs_diff(dz);
      tag2_ff  <= tag1_ff;
      last2_ff <= last1_ff;
      px2_ff   <= ax1_ff * ax1_ff;
      py2_ff   <= ay1_ff * ay1_ff;
      pz2_ff   <= az1_ff * az1_ff;
   end

   always_comb begin
      queue_wr.push      = v2_ff;
      queue_wr.item.tag  = tag2_ff;
      queue_wr.item.last = last2_ff;
      queue_wr.item.key  = KEY_W'(px2_ff) + KEY_W'(py2_ff) + KEY_W'(pz2_ff);
   end

endmodule

// ===== hdl/dsbf_queue.sv =====
// short fifo between the distance front end and the sorter
module dsbf_queue
   import dsbf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  queue_write_type        queue_wr,
   input  logic                   pop,
   output queue_head_type         head,
   output logic [QUEUE_CNT_W-1:0] count
);

   sort_item_type          entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_pop;

   assign do_pop = pop & (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (queue_wr.push) wr_ptr_in = wr_ptr_ff + 1'b1;
      if (do_pop)        rd_ptr_in = rd_ptr_ff + 1'b1;
      if (queue_wr.push && !do_pop)      count_in = count_ff + 1'b1;
      else if (!queue_wr.push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (queue_wr.push) entry_ff[wr_ptr_ff] <= queue_wr.item;
   end

   assign head.valid = count_ff != '0;
   assign head.item  = entry_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

// ===== hdl/dsbf_back.sv =====
// back end: chain of sorting cells, one insert per cycle while loading, then shift-out emission
module dsbf_back
   import dsbf_pkg::*;
#(
   parameter int MaxObjects = MAX_OBJECTS_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   input  queue_head_type        head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [TAG_W-1:0]      rsp_tag,
   output logic [KEY_W-1:0]      rsp_key,
   output logic                  rsp_last,
   output logic                  rsp_dropped
);

   localparam int CW = $clog2(MaxObjects + 1);

   logic [KEY_W-1:0]  key_ff [MaxObjects];
   logic [KEY_W-1:0]  key_in [MaxObjects];
   logic [TAG_W-1:0]  tag_ff [MaxObjects];
   logic [TAG_W-1:0]  tag_in [MaxObjects];
   logic [MaxObjects-1:0] keep;

   back_state_type    state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              overflow_ff, overflow_in;
   logic              insert, shift, out_free;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [TAG_W-1:0]  rsp_tag_ff;
   logic [KEY_W-1:0]  rsp_key_ff;
   logic              rsp_last_ff, rsp_dropped_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // a cell keeps its entry when it is filled and not nearer than the new one
   always_comb begin
      for (int i = 0; i < MaxObjects; i++) begin
         keep[i] = (count_ff > CW'(i)) && (key_ff[i] >= head.item.key);
      end
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      overflow_in = overflow_ff;
      pop         = 1'b0;
      insert      = 1'b0;
      shift       = 1'b0;
      unique case (state_ff)
         BACK_LOAD: begin
            if (head.valid) begin
               pop = 1'b1;
               if (count_ff == CW'(MaxObjects)) begin
                  overflow_in = 1'b1;
               end else begin
                  insert   = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               if (head.item.last) state_in = BACK_EMIT;
            end
         end
         BACK_EMIT: begin
            if (out_free) begin
               shift    = 1'b1;
               count_in = count_ff - 1'b1;
               if (count_ff == CW'(1)) begin
                  state_in    = BACK_LOAD;
                  overflow_in = 1'b0;
               end
            end
         end
         default: state_in = BACK_LOAD;
      endcase
   end

   for (genvar i = 0; i < MaxObjects; i++) begin : g_cell
      always_comb begin
         key_in[i] = key_ff[i];
         tag_in[i] = tag_ff[i];
         if (shift) begin
            if (i < MaxObjects - 1) begin
               key_in[i] = key_ff[(i < MaxObjects - 1) ? i + 1 : i];
               tag_in[i] = tag_ff[(i < MaxObjects - 1) ? i + 1 : i];
            end
         end else if (insert && !keep[i]) begin
            if (i == 0 || keep[(i > 0) ? i - 1 : 0]) begin
               key_in[i] = head.item.key;
               tag_in[i] = head.item.tag;
            end else begin
               key_in[i] = key_ff[(i > 0) ? i - 1 : 0];
               tag_in[i] = tag_ff[(i > 0) ? i - 1 : 0];
            end
         end
      end

      always_ff @(posedge clock) begin
         key_ff[i] <= key_in[i];
         tag_ff[i] <= tag_in[i];
      end
   end

   assign rsp_valid_in = shift ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_LOAD;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         rsp_tag_ff     <= tag_ff[0];
         rsp_key_ff     <= key_ff[0];
         rsp_last_ff    <= count_ff == CW'(1);
         rsp_dropped_ff <= overflow_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_tag     = rsp_tag_ff;
   assign rsp_key     = rsp_key_ff;
   assign rsp_last    = rsp_last_ff;
   assign rsp_dropped = rsp_dropped_ff;

endmodule

// ===== hdl/depth_sort_back_to_front.sv =====
// back-to-front depth sorter top level
// Takes a set of objects (tag plus signed Q15.8 position), one beat per cycle, and
// returns their tags farthest first from the camera, with the squared distance
// (16 fractional bits), tlast on the final result and tuser set on every result of a
// set in which objects past MaxObjects were dropped; equal distances keep load order.
// Each distance uses the camera registers as they stand when the object's beat is
// taken. While a set loads, one object is accepted per cycle: the two-stage distance
// pipe and the sorting cell chain each take one object a cycle, and the insert is a
// single parallel compare across all cells. The beat with tlast starts emission of N
// results (N = objects held), one per cycle while the result side is ready. The chain
// shifts toward the output during that time and takes no new objects, so the front
// side takes up to four more objects into the pipe and queue and then stalls until
// emission ends. tvalid of the first result rises once the last object's beat has
// passed both distance stages, the queue, the sorting cells and the output register.
module depth_sort_back_to_front
   import dsbf_pkg::*;
#(
   parameter int MaxObjects = MAX_OBJECTS_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   // object beats
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // object_tag, pos_x, pos_y, pos_z
   input  logic                  req_tlast,   // last_object
   // sorted result beats
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // sorted_tag, squared_distance, zero fill
   output logic                  rsp_tlast,   // last_result
   output logic                  rsp_tuser,   // dropped_any
   // configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   camera_type             camera;
   queue_write_type        queue_wr;
   queue_head_type         head;
   logic [QUEUE_CNT_W-1:0] queue_count;
   logic                   pop;
   logic [TAG_W-1:0]       out_tag;
   logic [KEY_W-1:0]       out_key;

   // camera position registers
   dsbf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .camera      (camera)
   );

   // distance pipe, ready held back by queue credit
   dsbf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_tag      (req_tdata[TAG_W-1:0]),
      .in_x        (req_tdata[TAG_W +: COORD_W]),
      .in_y        (req_tdata[TAG_W+COORD_W +: COORD_W]),
      .in_z        (req_tdata[TAG_W+2*COORD_W +: COORD_W]),
      .in_last     (req_tlast),
      .camera      (camera),
      .queue_count (queue_count),
      .queue_wr    (queue_wr)
   );

   // decouples distance pipe from sorter during emission
   dsbf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .queue_wr (queue_wr),
      .pop      (pop),
      .head     (head),
      .count    (queue_count)
   );

   // sorting chain and output register
   dsbf_back #(
      .MaxObjects (MaxObjects)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_tag     (out_tag),
      .rsp_key     (out_key),
      .rsp_last    (rsp_tlast),
      .rsp_dropped (rsp_tuser)
   );

   assign rsp_tdata = {{(RSP_DATA_W-TAG_W-KEY_W){1'b0}}, out_key, out_tag};

endmodule

// ===== tb/depth_sort_back_to_front_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the back-to-front depth sorter
module depth_sort_back_to_front_tb;
   import dsbf_pkg::*;

   localparam int CAPACITY   = MAX_OBJECTS_DEF;
   localparam int LIMIT      = 400000;   // cycles, far above the slowest correct run
   localparam int LONG_HOLD  = 300;      // result side hold-off, well past the queue depth
   localparam int SETTLE     = 16;       // pipe drain after the last beat
   localparam int RAND_ITEMS = 245;
   localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
   localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};

   // one object as offered on the request side
   typedef struct {
      logic [TAG_W-1:0]          tag;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic                      last;
   } object_type;

   // one sorted result as seen on the response side
   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [KEY_W-1:0] sq_dist;
      logic             last;
      logic             dropped;
   } sorted_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  req_tlast   = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // predictor state: camera registers and the set being loaded
   camera_type       cam = '0;
   logic [KEY_W-1:0] held_key [CAPACITY];
   logic [TAG_W-1:0] held_tag [CAPACITY];
   int               held_count   = 0;
   logic             held_dropped = 1'b0;

   object_type object_queue [$];   // objects waiting for the driver
   sorted_type sorted_due [$];     // results owed by the block, oldest first

   bit         idle_on       = 1'b1;
   int         hold_requests = 0;
   int         holds_done    = 0;
   int         errors        = 0;
   int         cycles        = 0;
   int         send_gap      = 0;
   int         recv_gap      = 0;
   int         recv_hold     = 0;
   int         sent          = 0;
   int         sets_done     = 0;
   object_type drv_ob;
   sorted_type got;
   sorted_type want;

   depth_sort_back_to_front uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),    // object_tag, pos_x, pos_y, pos_z
      .req_tlast   (req_tlast),    // last_object
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),    // sorted_tag, squared_distance, zero fill
      .rsp_tlast   (rsp_tlast),    // last_result
      .rsp_tuser   (rsp_tuser),    // dropped_any
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   // run time guard
   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT) begin
         $display("FAIL depth_sort_back_to_front");
         $finish;
      end
   end

   // distance with the camera as it stands now, then a stable insert:
   // the new object goes behind every held object at the same or larger distance
   function automatic void load_object(object_type ob);
      longint           dx;
      longint           dy;
      longint           dz;
      logic [KEY_W-1:0] key;
      int               slot;
      sorted_type       due;
      dx  = longint'($signed(ob.x)) - longint'($signed(cam.x));
      dy  = longint'($signed(ob.y)) - longint'($signed(cam.y));
      dz  = longint'($signed(ob.z)) - longint'($signed(cam.z));
      key = KEY_W'(dx * dx + dy * dy + dz * dz);
      if (held_count < CAPACITY) begin
         slot = held_count;
         while (slot > 0 && held_key[slot-1] < key) begin
            held_key[slot] = held_key[slot-1];
            held_tag[slot] = held_tag[slot-1];
            slot--;
         end
         held_key[slot] = key;
         held_tag[slot] = ob.tag;
         held_count++;
      end else begin
         // store full: object is lost but its last mark still counts
         held_dropped = 1'b1;
      end
      if (ob.last) begin
         for (int k = 0; k < held_count; k++) begin
            due = '{held_tag[k], held_key[k], k == held_count - 1, held_dropped};
            sorted_due.insert(sorted_due.size(), due);
         end
         held_count   = 0;
         held_dropped = 1'b0;
      end
   endfunction

   function automatic void push_object(logic [TAG_W-1:0] tag, logic signed [COORD_W-1:0] x,
                                       logic signed [COORD_W-1:0] y,
                                       logic signed [COORD_W-1:0] z, logic last);
      object_type ob;
      ob = '{tag, x, y, z, last};
      object_queue.insert(object_queue.size(), ob);
   endfunction

   // mostly tiny offsets so equal distances show up, plus full range and the rails
   function automatic logic signed [COORD_W-1:0] rand_coord();
      case ($urandom_range(0, 3))
         0, 1:    return COORD_W'($urandom_range(0, 8) - 4);
         2:       return COORD_W'($urandom);
         default: begin
            case ($urandom_range(0, 3))
               0:       return C_MIN;
               1:       return C_MAX;
               2:       return '0;
               default: return '1;
            endcase
         end
      endcase
   endfunction

   task automatic push_set(int n);
      for (int i = 0; i < n; i++)
         push_object(TAG_W'($urandom_range(0, 65535)), rand_coord(), rand_coord(),
                     rand_coord(), i == n - 1);
      sent += n;
      sets_done++;
   endtask

   // wait until the sender is empty, every result is in and the pipe has settled
   task automatic drain();
      while (object_queue.size() != 0 || req_tvalid || sorted_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // register write followed back to back by a read of the same register
   task automatic csr_write(csr_reg_type idx, logic signed [COORD_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= CSR_DATA_W'($signed(value));
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      // write lands at this edge
      case (idx)
         CSR_CAMERA_X: cam.x = value;
         CSR_CAMERA_Y: cam.y = value;
         default:      cam.z = value;
      endcase
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[COORD_W-1:0] !== value) begin
         errors++;
         $display("%0t: register %s read back: expected %h, actual %h", $time, idx.name(),
                  value, csr_prdata[COORD_W-1:0]);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_camera(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                             logic signed [COORD_W-1:0] z);
      csr_write(CSR_CAMERA_X, x);
      csr_write(CSR_CAMERA_Y, y);
      csr_write(CSR_CAMERA_Z, z);
   endtask

   // object driver: next beat goes up once the current one is taken or the bus is idle
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (object_queue.size() > 0) begin
            drv_ob = object_queue.pop_front();
            req_tdata  <= {drv_ob.z, drv_ob.y, drv_ob.x, drv_ob.tag};
            req_tlast  <= drv_ob.last;
            req_tvalid <= 1'b1;
            if (idle_on && $urandom_range(0, 7) == 0)
               send_gap = $urandom_range(1, 19);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // every object beat the block takes goes into the predictor
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         load_object('{req_tdata[TAG_W-1:0],
                       req_tdata[TAG_W+COORD_W-1:TAG_W],
                       req_tdata[TAG_W+2*COORD_W-1:TAG_W+COORD_W],
                       req_tdata[TAG_W+3*COORD_W-1:TAG_W+2*COORD_W],
                       req_tlast});
   end

   // result side ready: random stall bursts, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_requests != holds_done && rsp_tvalid) begin
         holds_done++;
         recv_hold = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (recv_hold > 0) begin
         recv_hold--;
         rsp_tready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (idle_on && $urandom_range(0, 7) == 0)
            recv_gap = $urandom_range(1, 19);
      end
   end

   // result checker against the oldest owed result
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[TAG_W-1:0], rsp_tdata[TAG_W+KEY_W-1:TAG_W], rsp_tlast, rsp_tuser};
         if (sorted_due.size() == 0) begin
            errors++;
            $display("%0t: expected no result, actual tag %h dist %h last %b drop %b",
                     $time, got.tag, got.sq_dist, got.last, got.dropped);
         end else begin
            want = sorted_due.pop_front();
            if (got !== want) begin
               errors++;
               $display("%0t: expected tag %h dist %h last %b drop %b,",
                        $time, want.tag, want.sq_dist, want.last, want.dropped,
                        " actual tag %h dist %h last %b drop %b",
                        got.tag, got.sq_dist, got.last, got.dropped);
            end
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // camera at origin after reset
      // lone object at the camera: one result, zero distance
      push_object(16'h0000, '0, '0, '0, 1'b1);
      // both rails and the origin
      push_object(16'hFFFF, C_MAX, C_MAX, C_MAX, 1'b0);
      push_object(16'h0001, C_MIN, C_MIN, C_MIN, 1'b0);
      push_object(16'h0002, '0, '0, '0, 1'b1);
      // four objects at equal distance along the axes keep load order
      push_object(16'h0010, 24'sd1, '0, '0, 1'b0);
      push_object(16'h0011, '0, -24'sd1, '0, 1'b0);
      push_object(16'h0012, '0, '0, 24'sd1, 1'b0);
      push_object(16'h0013, -24'sd1, '0, '0, 1'b1);
      drain();

      // largest distance, camera and object on opposite rails
      set_camera(C_MIN, C_MIN, C_MIN);
      push_object(16'h0020, C_MAX, C_MAX, C_MAX, 1'b0);
      push_object(16'h0021, C_MIN, C_MIN, C_MIN, 1'b1);
      drain();
      set_camera(C_MAX, C_MAX, C_MAX);
      push_object(16'h0022, C_MIN, C_MIN, C_MIN, 1'b1);
      drain();

      // camera moves in the middle of a set; the held distance must not change
      set_camera('0, '0, '0);
      push_object(16'h0030, 24'sd1024, '0, '0, 1'b0);
      drain();
      csr_write(CSR_CAMERA_X, 24'sd512);
      push_object(16'h0031, '0, '0, '0, 1'b1);
      drain();

      // full store with the receiver held off, then an overflowing set behind it
      set_camera(rand_coord(), rand_coord(), rand_coord());
      hold_requests++;
      push_set(CAPACITY);
      push_set(CAPACITY + 2);
      drain();

      // random sets, camera changes every few sets, no idling near the end
      while (sent < CAPACITY * 2 + 2 + RAND_ITEMS - 130) begin
         if (sets_done % 5 == 4) begin
            drain();
            if ($urandom_range(0, 1) == 0)
               set_camera(rand_coord(), rand_coord(), rand_coord());
            else
               set_camera(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
         end
         if (CAPACITY * 2 + 2 + RAND_ITEMS - 130 - sent < 40)
            idle_on = 1'b0;
         if ($urandom_range(0, 9) == 0)
            push_set($urandom_range(2, 12));
         else
            push_set($urandom_range(1, 6));
      end
      drain();

      if (errors == 0 && sorted_due.size() == 0)
         $display("PASS depth_sort_back_to_front");
      else
         $display("FAIL depth_sort_back_to_front");
      $finish;
   end

endmodule
